// ===== hdl/saesp_pkg.sv =====
// Shared widths, codes and interface structs for the sort and equal-split partitioner.
package saesp_pkg;

  localparam int MAX_PARTICLES_DEF = 64;
  localparam int KEY_W             = 32;
  localparam int TAG_W             = 16;
  localparam int POS_W             = 32;
  localparam int GROUP_W           = 6;
  localparam int GC_W              = 7;
  localparam int AXIS_W            = 2;
  localparam int CFG_IDX_W         = 1;
  localparam int CFG_DATA_W        = 7;
  localparam int GROUP_MAX         = 64;

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_START = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SORT_AXIS   = 1'b0,
    REG_GROUP_COUNT = 1'b1
  } reg_idx_t;

  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic               start;
    logic [GC_W-1:0]    gsize;
    logic [GROUP_W-1:0] group_last;
  } emit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } emit_sts_t;

endpackage

// ===== hdl/saesp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module saesp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/saesp_div.sv =====
// Restoring divider, one quotient bit per cycle, for the group size.
module saesp_div #(
  parameter int W = 7
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int STEP_W = $clog2(W + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [W-1:0]      rem;
  logic [W-1:0]      dvs;
  logic [W:0]        shifted;
  logic [W:0]        trial;

  assign shifted = {rem, quotient[W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (!trial[W]) begin
          rem      <= trial[W-1:0];
          quotient <= {quotient[W-2:0], 1'b1};
        end else begin
          rem      <= shifted[W-1:0];
          quotient <= {quotient[W-2:0], 1'b0};
        end
        step <= step + 1'b1;
        if (step == STEP_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/saesp_emit.sv =====
// Result stage: reads the sorted tags in order, assigns groups, output register and skid.
module saesp_emit #(
  parameter int MAX_PARTICLES = saesp_pkg::MAX_PARTICLES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  saesp_pkg::emit_ctl_t                  ctl,
  input  logic [$clog2(MAX_PARTICLES+1)-1:0]    count,
  output logic                                  rd_en,
  output logic [$clog2(MAX_PARTICLES)-1:0]      rd_addr,
  input  logic [saesp_pkg::TAG_W-1:0]           rd_data,
  output saesp_pkg::emit_sts_t                  sts,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [saesp_pkg::TAG_W-1:0]           out_tag,
  output logic [saesp_pkg::GROUP_W-1:0]         group_index,
  output logic                                  last
);

  import saesp_pkg::*;

  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int IDX_W = $clog2(MAX_PARTICLES);

  logic               active;
  logic               done;
  logic [CNT_W-1:0]   iss;
  logic [GC_W-1:0]    gsize;
  logic [GROUP_W-1:0] group_last;
  logic [GROUP_W-1:0] grp;
  logic [GC_W-1:0]    in_grp;

  logic               pend_valid;
  logic [GROUP_W-1:0] pend_group;
  logic               pend_last;

  logic               s_valid;
  logic [TAG_W-1:0]   s_tag;
  logic [GROUP_W-1:0] s_group;
  logic               s_last;

  logic               pop;
  logic [1:0]         occ_after;
  logic               issue;
  logic [GROUP_W-1:0] grp_val;
  logic               out_free;

  assign pop       = out_valid && !out_stall;
  assign occ_after = 2'(out_valid) + 2'(s_valid) + 2'(pend_valid) - 2'(pop);
  assign issue     = active && (iss < count) && (occ_after < 2'd2);
  assign rd_en     = issue;
  assign rd_addr   = iss[IDX_W-1:0];
  assign grp_val   = (gsize == '0) ? group_last : grp;
  assign out_free  = pop || !out_valid;

  assign sts = '{busy: active, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      pend_valid <= 1'b0;
      s_valid    <= 1'b0;
      out_valid  <= 1'b0;
      done       <= 1'b0;
    end else begin
      done       <= 1'b0;
      pend_valid <= issue;
      if (ctl.start) begin
        active     <= 1'b1;
        iss        <= '0;
        grp        <= '0;
        in_grp     <= '0;
        gsize      <= ctl.gsize;
        group_last <= ctl.group_last;
      end else if (issue) begin
        iss        <= iss + 1'b1;
        pend_group <= grp_val;
        pend_last  <= (iss == count - 1'b1);
        if (in_grp == gsize - 1'b1 && grp != group_last) begin
          grp    <= grp + 1'b1;
          in_grp <= '0;
        end else if (grp != group_last) begin
          in_grp <= in_grp + 1'b1;
        end
      end

      if (out_free) begin
        if (s_valid) begin
          out_valid   <= 1'b1;
          out_tag     <= s_tag;
          group_index <= s_group;
          last        <= s_last;
          s_valid     <= pend_valid;
          s_tag       <= rd_data;
          s_group     <= pend_group;
          s_last      <= pend_last;
        end else begin
          out_valid   <= pend_valid;
          out_tag     <= rd_data;
          group_index <= pend_group;
          last        <= pend_last;
        end
      end else if (pend_valid) begin
        s_valid <= 1'b1;
        s_tag   <= rd_data;
        s_group <= pend_group;
        s_last  <= pend_last;
      end

      if (pop && last) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/sort_and_equal_split_partitioner.sv =====
// Top level: particle store, rank-counting sort sequencer and result stage.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_stall  | cmd, particle_tag, pos_x, pos_y, pos_z
//  out     | output    | out_valid / out_stall| out_tag, group_index, last
//  cfg     | input     | cfg_wr_en            | cfg_index, cfg_data
//
// A load takes one write of the particle memory; loads stream back to back.
// A start with n stored particles first runs the group-size divider, then counts the rank of
// each particle over one read port by a sweep of the store, then emits n results at one per
// cycle while out_stall is low; in_stall stays high until the final result has been taken.
// Reset is synchronous; it empties the store and sets sort_axis 0, group_count 1.
// out_stall holds the result stage; a two-entry output buffer absorbs the read in flight.
module sort_and_equal_split_partitioner #(
  parameter int MAX_PARTICLES = saesp_pkg::MAX_PARTICLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [saesp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [saesp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              cmd,
  input  logic [saesp_pkg::TAG_W-1:0]       particle_tag,
  input  logic signed [saesp_pkg::POS_W-1:0] pos_x,
  input  logic signed [saesp_pkg::POS_W-1:0] pos_y,
  input  logic signed [saesp_pkg::POS_W-1:0] pos_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [saesp_pkg::TAG_W-1:0]       out_tag,
  output logic [saesp_pkg::GROUP_W-1:0]     group_index,
  output logic                              last
);

  import saesp_pkg::*;

  localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
  localparam int IDX_W  = $clog2(MAX_PARTICLES);
  localparam int WORD_W = KEY_W + TAG_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD_I,
    ST_LATCH,
    ST_SWEEP,
    ST_WRITE,
    ST_EMIT
  } state_t;

  state_t            state;
  logic [AXIS_W-1:0] sort_axis;
  logic [GC_W-1:0]   group_count;
  logic [CNT_W-1:0]  loaded_count;

  logic [CNT_W-1:0]  i_idx;
  logic [CNT_W-1:0]  j_idx;
  logic [IDX_W-1:0]  rank;
  logic              cmp_valid;
  logic [IDX_W-1:0]  cmp_idx;
  logic [KEY_W-1:0]  key_i;
  logic [TAG_W-1:0]  tag_i;
  logic [GC_W-1:0]   gsize;
  logic [GROUP_W-1:0] group_last;

  logic              in_accept;
  logic              load_ok;
  logic              start_ok;
  logic [KEY_W-1:0]  load_key;
  logic [GC_W-1:0]   gc_clamped;

  logic              dat_re;
  logic [IDX_W-1:0]  dat_raddr;
  logic [WORD_W-1:0] dat_rdata;
  logic [KEY_W-1:0]  key_j;
  logic              j_before;
  logic              sweep_issue;

  logic              div_done;
  logic [GC_W-1:0]   div_quo;

  logic              srt_re;
  logic [IDX_W-1:0]  srt_raddr;
  logic [TAG_W-1:0]  srt_rdata;

  emit_ctl_t         emit_ctl;
  emit_sts_t         emit_sts;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign load_ok   = in_accept && (cmd == CMD_LOAD) && (loaded_count < CNT_W'(MAX_PARTICLES));
  assign start_ok  = in_accept && (cmd == CMD_START) && (loaded_count != '0);

  always_comb begin
    unique case (sort_axis)
      AXIS_Y:  load_key = pos_y;
      AXIS_Z:  load_key = pos_z;
      default: load_key = pos_x;
    endcase
  end

  always_comb begin
    if (group_count == '0) begin
      gc_clamped = GC_W'(1);
    end else if (group_count > GC_W'(GROUP_MAX)) begin
      gc_clamped = GC_W'(GROUP_MAX);
    end else begin
      gc_clamped = group_count;
    end
  end

  assign sweep_issue = (state == ST_SWEEP) && (j_idx < loaded_count);
  assign dat_re      = (state == ST_RD_I) || sweep_issue;
  assign dat_raddr   = (state == ST_RD_I) ? i_idx[IDX_W-1:0] : j_idx[IDX_W-1:0];
  assign key_j       = dat_rdata[WORD_W-1:TAG_W];
  assign j_before    = ($signed(key_j) < $signed(key_i)) ||
                       ((key_j == key_i) && (CNT_W'(cmp_idx) < i_idx));

  saesp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_PARTICLES)
  ) u_particle_ram (
    .clk   (clk),
    .we    (load_ok),
    .waddr (loaded_count[IDX_W-1:0]),
    .wdata ({load_key, particle_tag}),
    .re    (dat_re),
    .raddr (dat_raddr),
    .rdata (dat_rdata)
  );

  saesp_ram #(
    .WIDTH (TAG_W),
    .DEPTH (MAX_PARTICLES)
  ) u_sorted_ram (
    .clk   (clk),
    .we    (state == ST_WRITE),
    .waddr (rank),
    .wdata (tag_i),
    .re    (srt_re),
    .raddr (srt_raddr),
    .rdata (srt_rdata)
  );

  saesp_div #(
    .W (GC_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start_ok),
    .dividend (GC_W'(loaded_count)),
    .divisor  (gc_clamped),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign emit_ctl.start      = (state == ST_WRITE) && (i_idx == loaded_count - 1'b1);
  assign emit_ctl.gsize      = gsize;
  assign emit_ctl.group_last = group_last;

  saesp_emit #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .ctl         (emit_ctl),
    .count       (loaded_count),
    .rd_en       (srt_re),
    .rd_addr     (srt_raddr),
    .rd_data     (srt_rdata),
    .sts         (emit_sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_tag     (out_tag),
    .group_index (group_index),
    .last        (last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sort_axis    <= '0;
      group_count  <= GC_W'(1);
      loaded_count <= '0;
      cmp_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_SORT_AXIS:   sort_axis   <= cfg_data[AXIS_W-1:0];
          REG_GROUP_COUNT: group_count <= cfg_data[GC_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (load_ok) begin
            loaded_count <= loaded_count + 1'b1;
          end
          if (start_ok) begin
            group_last <= GROUP_W'(gc_clamped - 1'b1);
            state      <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            gsize <= div_quo;
            i_idx <= '0;
            state <= ST_RD_I;
          end
        end
        ST_RD_I: begin
          state <= ST_LATCH;
        end
        ST_LATCH: begin
          key_i     <= dat_rdata[WORD_W-1:TAG_W];
          tag_i     <= dat_rdata[TAG_W-1:0];
          j_idx     <= '0;
          rank      <= '0;
          cmp_valid <= 1'b0;
          state     <= ST_SWEEP;
        end
        ST_SWEEP: begin
          cmp_valid <= sweep_issue;
          cmp_idx   <= j_idx[IDX_W-1:0];
          if (sweep_issue) begin
            j_idx <= j_idx + 1'b1;
          end
          if (cmp_valid && j_before) begin
            rank <= rank + 1'b1;
          end
          if (!sweep_issue && !cmp_valid) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          i_idx <= i_idx + 1'b1;
          if (i_idx == loaded_count - 1'b1) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_RD_I;
          end
        end
        ST_EMIT: begin
          if (emit_sts.done) begin
            loaded_count <= '0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CNT_W'(MAX_PARTICLES))
    else $error("particle count beyond capacity");

  a_out_only_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_EMIT))
    else $error("result shown outside the emit phase");

  a_rank_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (CNT_W'(rank) < loaded_count))
    else $error("rank out of range of the stored particles");

  a_done_empties: assert property (@(posedge clk) disable iff (rst)
    emit_sts.done |=> (loaded_count == '0) && (state == ST_IDLE) && !emit_sts.busy)
    else $error("store not emptied after the final result");

endmodule

// ===== sim/tb_sort_and_equal_split_partitioner.sv =====
// Self-checking testbench for the sort and equal-split partitioner.
module tb_sort_and_equal_split_partitioner;
  timeunit 1ns;
  timeprecision 1ps;

  import saesp_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 420;
  localparam int HOLD_CYCLES  = 600;
  localparam int EXP_DEPTH    = 128;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [GROUP_W-1:0] grp;
    logic               lst;
  } part_res_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_LOAD,
    ROW_START
  } row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    reg_idx_t            rsel;
    logic [GC_W-1:0]     data;
    logic [TAG_W-1:0]    tag;
    logic [POS_W-1:0]    px;
    logic [POS_W-1:0]    py;
    logic [POS_W-1:0]    pz;
    logic                pin;
    logic [TAG_W-1:0]    ptag;
    logic [GROUP_W-1:0]  pgrp;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  reg_idx_t              cfg_index = REG_SORT_AXIS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  cmd_t                  cmd = CMD_LOAD;
  logic [TAG_W-1:0]      particle_tag = '0;
  logic [POS_W-1:0]      pos_x = '0;
  logic [POS_W-1:0]      pos_y = '0;
  logic [POS_W-1:0]      pos_z = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [TAG_W-1:0]      out_tag;
  logic [GROUP_W-1:0]    group_index;
  logic                  last;

  sort_and_equal_split_partitioner uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .particle_tag (particle_tag),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_tag      (out_tag),
    .group_index  (group_index),
    .last         (last)
  );

  // particle store mirror and register copies
  logic signed [KEY_W-1:0] mdl_key [MAX_PARTICLES_DEF];
  logic [TAG_W-1:0]        mdl_tag [MAX_PARTICLES_DEF];
  int                      mdl_count = 0;
  logic [AXIS_W-1:0]       mdl_axis = '0;
  logic [GC_W-1:0]         mdl_gcnt = 7'd1;

  part_res_t pending_groups [EXP_DEPTH];
  int        exp_wr = 0;
  int        exp_rd = 0;
  int        mismatches = 0;
  int        useful_items = 0;
  int        cycle_count = 0;
  bit        quiet = 1'b0;
  bit        hold_armed = 1'b0;
  int        hold_left = 0;

  dir_row_t dir_rows [23] = '{
    '{ROW_START, REG_SORT_AXIS, 7'd0, 16'hBEEF, 32'h1, 32'h2, 32'h3, 1'b0, 16'h0, 6'd0},
    '{ROW_LOAD, REG_SORT_AXIS, 7'd0, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
      1'b0, 16'h0, 6'd0},
    '{ROW_START, REG_SORT_AXIS, 7'd0, 16'h0, 32'hFFFF_FFFF, 32'h0, 32'h0,
      1'b1, 16'hFFFF, 6'd0},
    '{ROW_CFG, REG_GROUP_COUNT, 7'd64, 16'h0, 32'h0, 32'h0, 32'h0, 1'b0, 16'h0, 6'd0},
    '{ROW_LOAD, REG_SORT_AXIS, 7'd0, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
      1'b0, 16'h0, 6'd0},
    '{ROW_START, REG_SORT_AXIS, 7'd0, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'h0,
      1'b1, 16'h0000, 6'd63},
    '{ROW_CFG, REG_GROUP_COUNT, 7'd0, 16'h0, 32'h0, 32'h0, 32'h0, 1'b0, 16'h0, 6'd0},
    '{ROW_LOAD, REG_SORT_AXIS, 7'd0, 16'h1234, 32'h0001_0000, 32'h0, 32'h0,
      1'b0, 16'h0, 6'd0},
    '{ROW_START, REG_SORT_AXIS, 7'd0, 16'h0, 32'h0, 32'h0, 32'h0, 1'b1, 16'h1234, 6'd0},
    '{ROW_CFG, REG_GROUP_COUNT, 7'h7F, 16'h0, 32'h0, 32'h0, 32'h0, 1'b0, 16'h0, 6'd0},
    '{ROW_LOAD, REG_SORT_AXIS, 7'd0, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0,
      1'b0, 16'h0, 6'd0},
    '{ROW_START, REG_SORT_AXIS, 7'd0, 16'h0, 32'h0, 32'h0, 32'h0, 1'b1, 16'h5555, 6'd63},
    '{ROW_CFG, REG_SORT_AXIS, 7'd1, 16'h0, 32'h0, 32'h0, 32'h0, 1'b0, 16'h0, 6'd0},
    '{ROW_CFG, REG_GROUP_COUNT, 7'd3, 16'h0, 32'h0, 32'h0, 32'h0, 1'b0, 16'h0, 6'd0},
    '{ROW_LOAD, REG_SORT_AXIS, 7'd0, 16'h0A01, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
      1'b0, 16'h0, 6'd0},
    '{ROW_LOAD, REG_SORT_AXIS, 7'd0, 16'h0A02, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
      1'b0, 16'h0, 6'd0},
    '{ROW_LOAD, REG_SORT_AXIS, 7'd0, 16'h0A03, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
      1'b0, 16'h0, 6'd0},
    '{ROW_CFG, REG_SORT_AXIS, 7'd2, 16'h0, 32'h0, 32'h0, 32'h0, 1'b0, 16'h0, 6'd0},
    '{ROW_LOAD, REG_SORT_AXIS, 7'd0, 16'h0A04, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000,
      1'b0, 16'h0, 6'd0},
    '{ROW_CFG, REG_SORT_AXIS, 7'h7B, 16'h0, 32'h0, 32'h0, 32'h0, 1'b0, 16'h0, 6'd0},
    '{ROW_LOAD, REG_SORT_AXIS, 7'd0, 16'h0A05, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
      1'b0, 16'h0, 6'd0},
    '{ROW_LOAD, REG_SORT_AXIS, 7'd0, 16'h0A06, 32'hFFFF_FFFF, 32'h0, 32'h0,
      1'b0, 16'h0, 6'd0},
    '{ROW_START, REG_SORT_AXIS, 7'd0, 16'hC0DE, 32'h0, 32'h0, 32'h0, 1'b0, 16'h0, 6'd0}
  };

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, a quiet stretch and one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_armed && out_valid) begin
      hold_armed = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 19);
    end
  end

  always @(posedge clk) begin : check_results
    part_res_t got;
    part_res_t want;
    got = '{out_tag, group_index, last};
    if (!rst && out_valid && !out_stall) begin
      if (exp_wr == exp_rd) begin
        if (mismatches < 10)
          $display("unexpected transaction: tag %h group %0d last %b", out_tag,
                   group_index, last);
        mismatches++;
      end else begin
        want = pending_groups[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (got !== want) begin
          if (mismatches < 10)
            $display("mismatch: tag exp %h got %h, group exp %0d got %0d, last exp %b got %b",
                     want.tag, got.tag, want.grp, got.grp, want.lst, got.lst);
          mismatches++;
        end
      end
    end
  end

  // store one particle, or sort the store and queue the grouped transactions or a pinned one
  task automatic apply_item(input cmd_t c, input logic [TAG_W-1:0] tg,
                            input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                            input logic [POS_W-1:0] pz, input bit pinned,
                            input part_res_t pin_res);
    int ord [MAX_PARTICLES_DEF];
    int n;
    int j;
    int gc;
    int gsize;
    int g;
    if (c == CMD_LOAD) begin
      if (mdl_count < MAX_PARTICLES_DEF) begin
        mdl_key[mdl_count] = (mdl_axis == AXIS_Y) ? py : (mdl_axis == AXIS_Z) ? pz : px;
        mdl_tag[mdl_count] = tg;
        mdl_count++;
        useful_items++;
      end
    end else if (mdl_count > 0) begin
      n = mdl_count;
      for (int i = 0; i < n; i++) begin
        j = i;
        while (j > 0 && mdl_key[ord[j-1]] > mdl_key[i]) begin
          ord[j] = ord[j-1];
          j--;
        end
        ord[j] = i;
      end
      gc = (mdl_gcnt == 0) ? 1 : (mdl_gcnt > GROUP_MAX) ? GROUP_MAX : int'(mdl_gcnt);
      gsize = n / gc;
      if (pinned) begin
        pending_groups[exp_wr % EXP_DEPTH] = pin_res;
        exp_wr++;
      end else begin
        for (int i = 0; i < n; i++) begin
          g = (gsize == 0) ? gc - 1 : i / gsize;
          if (g > gc - 1)
            g = gc - 1;
          pending_groups[exp_wr % EXP_DEPTH] = '{mdl_tag[ord[i]], g[GROUP_W-1:0], (i == n - 1)};
          exp_wr++;
        end
      end
      mdl_count = 0;
      useful_items++;
    end
  endtask

  task automatic send_item(input cmd_t c, input logic [TAG_W-1:0] tg,
                           input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                           input logic [POS_W-1:0] pz, input bit pinned,
                           input part_res_t pin_res);
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    particle_tag <= tg;
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    do @(posedge clk); while (in_stall);
    apply_item(c, tg, px, py, pz, pinned, pin_res);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [CFG_DATA_W-1:0] d);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    if (r == REG_SORT_AXIS)
      mdl_axis = d[AXIS_W-1:0];
    else
      mdl_gcnt = d;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [POS_W-1:0] rand_coord();
    logic [15:0] whole;
    whole = 16'($urandom_range(4) - 2);
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return {whole, 16'h0};
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    dir_row_t row;
    int n;
    int batch;
    int pick;
    logic [CFG_DATA_W-1:0] gval;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      case (row.kind)
        ROW_CFG: begin
          write_reg(row.rsel, row.data);
        end
        ROW_LOAD: begin
          send_item(CMD_LOAD, row.tag, row.px, row.py, row.pz, 1'b0, '0);
        end
        default: begin
          send_item(CMD_START, row.tag, row.px, row.py, row.pz, row.pin,
                    '{row.ptag, row.pgrp, 1'b1});
        end
      endcase
    end

    useful_items = 0;
    batch = 0;
    while (useful_items < RANDOM_ITEMS) begin
      quiet = (batch >= 3 && batch < 9);
      if (batch != 11 && batch != 12 && $urandom_range(3) == 0)
        write_reg(REG_SORT_AXIS, CFG_DATA_W'($urandom_range(127)));
      if (batch != 11 && batch != 12 && $urandom_range(3) == 0) begin
        case ($urandom_range(7))
          0: gval = CFG_DATA_W'($urandom_range(127));
          1: gval = 7'd64;
          default: gval = CFG_DATA_W'($urandom_range(8, 1));
        endcase
        write_reg(REG_GROUP_COUNT, gval);
      end
      pick = $urandom_range(99);
      if (pick < 80)
        n = $urandom_range(12, 1);
      else if (pick < 95)
        n = $urandom_range(40, 13);
      else
        n = $urandom_range(68, 64);
      if (batch == 2)
        n = 66;
      if (batch == 11) begin
        hold_armed = 1'b1;
        n = 30;
      end
      for (int i = 0; i < n; i++) begin
        if (batch != 11 && n > 4 && i == n / 2 && $urandom_range(4) == 0)
          write_reg(REG_SORT_AXIS, CFG_DATA_W'($urandom_range(127)));
        send_item(CMD_LOAD, TAG_W'($urandom), rand_coord(), rand_coord(), rand_coord(),
                  1'b0, '0);
      end
      send_item(CMD_START, TAG_W'($urandom), $urandom, $urandom, $urandom, 1'b0, '0);
      if ($urandom_range(9) == 0)
        send_item(CMD_START, TAG_W'($urandom), $urandom, $urandom, $urandom, 1'b0, '0);
      batch++;
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
